// ===== design/saoc_pkg.sv =====
// Shared types, sizes and index helpers for the sorted-array occurrence counter.
package saoc_pkg;

   localparam int DEPTH   = 1024;
   localparam int ELEM_W  = 32;
   localparam int OCC_W   = 11;
   localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W   = $clog2(DEPTH + 1);

   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   typedef logic signed [ELEM_W-1:0] elem_type;
   typedef logic        [IDX_W-1:0]  idx_type;
   typedef logic        [CNT_W-1:0]  cnt_type;
   typedef logic        [OCC_W-1:0]  occ_type;

   // Midpoint rounding down, for the lower-bound search.
   function automatic idx_type mid_low(input idx_type lo, input idx_type hi);
      idx_type diff;
      diff = hi - lo;
      return lo + (diff >> 1);
   endfunction

   // Midpoint rounding up, for the upper-bound search.
   function automatic idx_type mid_high(input idx_type lo, input idx_type hi);
      cnt_type span;
      span = cnt_type'(hi - lo) + cnt_type'(1);
      return lo + idx_type'(span >> 1);
   endfunction

endpackage

// ===== design/saoc_if.sv =====
// Request and response channel interfaces for the occurrence counter.
interface saoc_req_if import saoc_pkg::*; ();
   logic     valid;
   logic     ready;
   logic     func;
   elem_type value;
   logic     first;

   modport source (output valid, output func, output value, output first, input ready);
   modport sink   (input valid, input func, input value, input first, output ready);
endinterface

interface saoc_rsp_if import saoc_pkg::*; ();
   logic    valid;
   logic    ready;
   occ_type occurrences;

   modport source (output valid, output occurrences, input ready);
   modport sink   (input valid, input occurrences, output ready);
endinterface

// ===== design/sorted_array_occurrence_count_top.sv =====
// Top level of the sorted-array occurrence counter: element store plus search sequencer.
//
// The block keeps up to DEPTH (1024) signed 32-bit elements in one RAM and counts
// how many equal a queried target, assuming the elements were loaded in ascending
// order. A load word (func = 0) returns nothing; a load with first set restarts
// the array, and loads past DEPTH are dropped. A query word (func = 1) returns one
// response word: a lower-bound binary search, one compare of the element found
// there, then, on a match, an upper-bound binary search. Every search step is
// one RAM read through the single read port followed by one signed compare, and
// each search takes at most ceil(log2(n)) steps for n stored elements; an empty
// array is answered with no search. The request side is ready only while the
// sequencer is idle; the response stays valid until taken. The RAM has no reset
// and needs no clearing pass: searches read only entries below the element count.
// Unsorted contents give whatever the two searches land on.
module sorted_array_occurrence_count_top import saoc_pkg::*; (
   input  logic   clock,
   input  logic   reset,
   saoc_req_if.sink   req_ch,
   saoc_rsp_if.source rsp_ch
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_LB,
      S_CHK,
      S_UB,
      S_RESP
   } state_type;

   state_type state_ff, state_in;
   cnt_type   count_ff, count_in;
   idx_type   lo_ff, lo_in;
   idx_type   hi_ff, hi_in;
   idx_type   mid_ff, mid_in;
   idx_type   start_ff, start_in;
   elem_type  target_ff, target_in;
   cnt_type   result_ff, result_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // RAM side
   logic        wr_en;
   idx_type     wr_addr;
   elem_type    wr_data;
   idx_type     rd_addr;
   logic [ELEM_W-1:0] rd_raw;
   elem_type    rd_elem;

   // step temporaries
   cnt_type   load_base;
   idx_type   lo_n, hi_n;
   idx_type   last_idx;

   saoc_ram #(
      .WIDTH (ELEM_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   assign rd_elem = elem_type'(rd_raw);
   assign last_idx = idx_type'(count_ff - cnt_type'(1));

   assign req_ch.ready       = (state_ff == S_IDLE);
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.occurrences = occ_type'(result_ff);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      start_in     = start_ff;
      target_in    = target_ff;
      result_in    = result_ff;
      rsp_valid_in = rsp_valid_ff;
      wr_en        = 1'b0;
      wr_addr      = idx_type'(0);
      wr_data      = req_ch.value;
      rd_addr      = mid_ff;
      load_base    = req_ch.first ? cnt_type'(0) : count_ff;
      lo_n         = lo_ff;
      hi_n         = hi_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               if (req_ch.func == FUNC_LOAD) begin
                  // append; a restart always stores its element
                  count_in = load_base;
                  if (load_base < cnt_type'(DEPTH)) begin
                     wr_en    = 1'b1;
                     wr_addr  = idx_type'(load_base);
                     count_in = load_base + cnt_type'(1);
                  end
               end else begin
                  target_in = req_ch.value;
                  lo_in     = idx_type'(0);
                  hi_in     = last_idx;
                  if (count_ff == cnt_type'(0)) begin
                     result_in    = cnt_type'(0);
                     rsp_valid_in = 1'b1;
                     state_in     = S_RESP;
                  end else if (last_idx != idx_type'(0)) begin
                     mid_in   = mid_low(idx_type'(0), last_idx);
                     rd_addr  = mid_in;
                     state_in = S_LB;
                  end else begin
                     rd_addr  = idx_type'(0);
                     state_in = S_CHK;
                  end
               end
            end
         end

         S_LB: begin
            // narrow toward the first element not below the target
            if (rd_elem < target_ff) begin
               lo_n = mid_ff + idx_type'(1);
            end else begin
               hi_n = mid_ff;
            end
            lo_in = lo_n;
            hi_in = hi_n;
            if (lo_n < hi_n) begin
               mid_in  = mid_low(lo_n, hi_n);
               rd_addr = mid_in;
            end else begin
               rd_addr  = lo_n;
               state_in = S_CHK;
            end
         end

         S_CHK: begin
            if (rd_elem != target_ff) begin
               result_in    = cnt_type'(0);
               rsp_valid_in = 1'b1;
               state_in     = S_RESP;
            end else begin
               start_in = lo_ff;
               hi_in    = last_idx;
               if (lo_ff < last_idx) begin
                  mid_in   = mid_high(lo_ff, last_idx);
                  rd_addr  = mid_in;
                  state_in = S_UB;
               end else begin
                  result_in    = cnt_type'(1);
                  rsp_valid_in = 1'b1;
                  state_in     = S_RESP;
               end
            end
         end

         S_UB: begin
            // narrow toward the last element not above the target
            if (rd_elem > target_ff) begin
               hi_n = mid_ff - idx_type'(1);
            end else begin
               lo_n = mid_ff;
            end
            lo_in = lo_n;
            hi_in = hi_n;
            if (lo_n < hi_n) begin
               mid_in  = mid_high(lo_n, hi_n);
               rd_addr = mid_in;
            end else begin
               result_in    = cnt_type'(hi_n) - cnt_type'(start_ff) + cnt_type'(1);
               rsp_valid_in = 1'b1;
               state_in     = S_RESP;
            end
         end

         S_RESP: begin
            // hold the result until the sink takes it
            if (rsp_ch.ready) begin
               rsp_valid_in = 1'b0;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      mid_ff    <= mid_in;
      start_ff  <= start_in;
      target_ff <= target_in;
      result_ff <= result_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= cnt_type'(0);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // The element count never runs past the array size.
   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= cnt_type'(DEPTH))
      else $error("element count exceeds depth");

   // A search step always works on a nonempty open interval.
   a_search_interval: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LB || state_ff == S_UB) |-> (lo_ff < hi_ff && mid_ff <= hi_ff))
      else $error("search interval collapsed during a step");

   // A reported count never exceeds the stored elements.
   a_result_bounded: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> result_ff <= count_ff)
      else $error("occurrence count above element count");

   // A response word is pending exactly in the response state.
   a_resp_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff == (state_ff == S_RESP))
      else $error("response valid out of step with sequencer");

endmodule

// ===== design/saoc_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
module saoc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
